>>> src/cwl_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the checked word loader.
// No dependencies; imported by every cwl_* module and the top level.
package cwl_pkg;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_START_MARKER = 2'd0,
    CFG_LOAD_BASE    = 2'd1,
    CFG_DONE_CODE    = 2'd2
  } cfg_idx_t;

  localparam logic [31:0] START_MARKER_RST = 32'hF0F0_F0F0;
  localparam logic [31:0] LOAD_BASE_RST    = 32'h1000_0000;
  localparam logic [7:0]  DONE_CODE_RST    = 8'h02;

  // word mod 230 by reciprocal: q_est = (word * CHECK_RECIP) >> RECIP_SHIFT
  // lands on the true quotient or one below, so the remainder is < 2*230.
  localparam int unsigned CHECK_DIV   = 230;
  localparam logic [31:0] CHECK_RECIP = 32'd2390242669;  // floor(2^39 / 230)
  localparam int unsigned RECIP_SHIFT = 39;
  localparam int unsigned REM_W       = 9;                // holds values below 460

  // Output queue: sized for every result still in flight or waiting
  localparam int unsigned OUT_DEPTH = 4;
  localparam int unsigned OUT_PTR_W = 2;
  localparam int unsigned OUT_CNT_W = 3;

  typedef struct packed {
    logic        is_start;    // marker seen while idle
    logic        done;        // record status matched done code
    logic [31:0] word;
    logic [7:0]  check_byte;
  } item_t;

  typedef struct packed {
    logic        ack_code;
    logic        write_enable;
    logic [31:0] write_address;
    logic [31:0] write_data;
    logic        block_flush;
    logic [31:0] block_flush_address;
    logic        final_flush;
    logic [31:0] final_flush_address;
    logic        launch;
  } result_t;

endpackage

>>> src/cwl_front.sv
`timescale 1ns / 1ps
// Front end: configuration registers, marker/done decode, input stage register.
// Depends on cwl_pkg.
module cwl_front
  import cwl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [31:0] in_word,
  input  logic [7:0]  in_check_byte,
  input  logic [7:0]  in_record_status,
  output logic        enter,
  output logic        s0_vld,
  output item_t       s0_item,
  output logic [31:0] load_base
);

  logic [31:0] start_marker_r;
  logic [31:0] load_base_r;
  logic [7:0]  done_code_r;
  logic        loading_r, loading_nxt;
  logic        s0_vld_r;
  item_t       s0_item_r, s0_item_nxt;
  logic        accept, is_marker, is_done;

  assign cfg_ready = 1'b1;

  always_comb begin
    accept      = in_valid & ~in_stall;
    is_marker   = (in_word == start_marker_r);
    is_done     = (in_record_status == done_code_r);
    // idle non-marker words vanish here
    enter       = accept & (loading_r | is_marker);
    loading_nxt = loading_r;
    if (accept) begin
      if (!loading_r) begin
        if (is_marker) loading_nxt = 1'b1;
      end else if (is_done) begin
        loading_nxt = 1'b0;
      end
    end
    s0_item_nxt.is_start   = ~loading_r;
    s0_item_nxt.done       = is_done;
    s0_item_nxt.word       = in_word;
    s0_item_nxt.check_byte = in_check_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_marker_r <= START_MARKER_RST;
      load_base_r    <= LOAD_BASE_RST;
      done_code_r    <= DONE_CODE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_START_MARKER: start_marker_r <= cfg_data;
        CFG_LOAD_BASE:    load_base_r    <= cfg_data;
        CFG_DONE_CODE:    done_code_r    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loading_r <= 1'b0;
      s0_vld_r  <= 1'b0;
    end else begin
      loading_r <= loading_nxt;
      s0_vld_r  <= enter;
    end
  end

  always_ff @(posedge clk) begin
    if (enter) s0_item_r <= s0_item_nxt;
  end

  assign s0_vld    = s0_vld_r;
  assign s0_item   = s0_item_r;
  assign load_base = load_base_r;

endmodule

>>> src/cwl_check.sv
`timescale 1ns / 1ps
// Check stage: reciprocal multiply for word mod 230, then remainder compare.
// Depends on cwl_pkg.
module cwl_check
  import cwl_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  s0_vld,
  input  item_t s0_item,
  output logic  s1_vld,
  output item_t s1_item,
  output logic  match
);

  logic [63:0]      prod;
  logic [REM_W-1:0] q_lo_nxt;
  logic             s1_vld_r;
  item_t            s1_item_r;
  logic [REM_W-1:0] q_lo_r;
  logic [REM_W-1:0] rem_raw, rem_fix;

  always_comb begin
    prod     = {32'd0, s0_item.word} * {32'd0, CHECK_RECIP};
    // only the low bits of the quotient matter: the remainder fits in REM_W bits
    q_lo_nxt = prod[RECIP_SHIFT +: REM_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s1_vld_r <= 1'b0;
    else        s1_vld_r <= s0_vld;
  end

  always_ff @(posedge clk) begin
    if (s0_vld) begin
      s1_item_r <= s0_item;
      q_lo_r    <= q_lo_nxt;
    end
  end

  always_comb begin
    rem_raw = s1_item_r.word[REM_W-1:0] - (q_lo_r * REM_W'(CHECK_DIV));
    // quotient estimate may be one short: fold once
    rem_fix = (rem_raw >= REM_W'(CHECK_DIV)) ? rem_raw - REM_W'(CHECK_DIV) : rem_raw;
    match   = (rem_fix == {1'b0, s1_item_r.check_byte});
  end

  assign s1_vld  = s1_vld_r;
  assign s1_item = s1_item_r;

endmodule

>>> src/cwl_seq.sv
`timescale 1ns / 1ps
// Load sequencer: write pointer, block tracking and result formation.
// Depends on cwl_pkg.
module cwl_seq
  import cwl_pkg::*;
#(
  parameter int unsigned FLUSH_WORDS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        s1_vld,
  input  item_t       s1_item,
  input  logic        match,
  input  logic [31:0] load_base,
  output logic        push,
  output result_t     push_res
);

  localparam int unsigned CNT_W = (FLUSH_WORDS > 1) ? $clog2(FLUSH_WORDS) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FLUSH_WORDS - 1);

  logic [31:0]      next_addr_r, next_addr_nxt;
  logic [31:0]      blk_addr_r, blk_addr_nxt;
  logic [CNT_W-1:0] blk_cnt_r, blk_cnt_nxt;
  logic [31:0]      addr_inc;

  always_comb begin
    push          = s1_vld;
    push_res      = '0;
    next_addr_nxt = next_addr_r;
    blk_addr_nxt  = blk_addr_r;
    blk_cnt_nxt   = blk_cnt_r;
    addr_inc      = next_addr_r + 32'd4;
    if (s1_vld) begin
      if (s1_item.is_start) begin
        next_addr_nxt = load_base;
        blk_addr_nxt  = load_base;
        blk_cnt_nxt   = '0;
      end else begin
        if (match) begin
          push_res.write_enable  = 1'b1;
          push_res.write_address = next_addr_r;
          push_res.write_data    = s1_item.word;
          next_addr_nxt          = addr_inc;
          if (blk_cnt_r == CNT_LAST) begin
            push_res.block_flush         = 1'b1;
            push_res.block_flush_address = blk_addr_r;
            blk_addr_nxt                 = addr_inc;
            blk_cnt_nxt                  = '0;
          end else begin
            blk_cnt_nxt = blk_cnt_r + CNT_W'(1);
          end
        end else begin
          push_res.ack_code = 1'b1;
        end
        if (s1_item.done) begin
          // final flush covers the block as it stands after this record
          push_res.final_flush         = 1'b1;
          push_res.final_flush_address = blk_addr_nxt;
          push_res.launch              = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_addr_r <= '0;
      blk_addr_r  <= '0;
      blk_cnt_r   <= '0;
    end else begin
      next_addr_r <= next_addr_nxt;
      blk_addr_r  <= blk_addr_nxt;
      blk_cnt_r   <= blk_cnt_nxt;
    end
  end

endmodule

>>> src/cwl_queue.sv
`timescale 1ns / 1ps
// Output queue with occupancy tracking; drives the registered input stall.
// Depends on cwl_pkg.
module cwl_queue
  import cwl_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    enter,
  input  logic    push,
  input  result_t push_res,
  input  logic    out_stall,
  output logic    out_valid,
  output result_t out_res,
  output logic    in_stall
);

  result_t              mem_r [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [OUT_CNT_W-1:0] fifo_cnt_r, fifo_cnt_nxt;
  logic [OUT_CNT_W-1:0] occ_r, occ_nxt;
  logic                 in_stall_r, in_stall_nxt;
  logic                 pop;

  always_comb begin
    out_valid    = (fifo_cnt_r != '0);
    out_res      = mem_r[rd_ptr_r];
    pop          = out_valid & ~out_stall;
    fifo_cnt_nxt = fifo_cnt_r + OUT_CNT_W'(push) - OUT_CNT_W'(pop);
    // occupancy counts transactions in the pipeline plus queued results
    occ_nxt      = occ_r + OUT_CNT_W'(enter) - OUT_CNT_W'(pop);
    in_stall_nxt = (occ_nxt >= OUT_CNT_W'(OUT_DEPTH));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      fifo_cnt_r <= '0;
      occ_r      <= '0;
      in_stall_r <= 1'b0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + OUT_PTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + OUT_PTR_W'(1);
      fifo_cnt_r <= fifo_cnt_nxt;
      occ_r      <= occ_nxt;
      in_stall_r <= in_stall_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_res;
  end

  assign in_stall = in_stall_r;

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (fifo_cnt_r < OUT_CNT_W'(OUT_DEPTH)) || pop)
    else $error("output queue overflow");

  a_occ_covers_queue: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r >= fifo_cnt_r)
    else $error("occupancy below queued results");

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    enter |=> occ_r <= OUT_CNT_W'(OUT_DEPTH))
    else $error("occupancy above queue depth");

endmodule

>>> src/checked_word_loader_top.sv
`timescale 1ns / 1ps
// Path from input acceptance to result valid: stage register, multiply register,
// output queue. Throughput: one transaction per cycle while out_stall is low, set by the
// two-stage check pipeline and the 4-entry output queue that backs the input stall.
// Reset (rst_n low, synchronous): back to idle, pointers and counters cleared,
// queue emptied, configuration registers return to their defaults.
module checked_word_loader_top
  import cwl_pkg::*;
#(
  parameter int unsigned FLUSH_WORDS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_word,
  input  logic [7:0]  in_check_byte,
  input  logic [7:0]  in_record_status,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_ack_code,
  output logic        out_write_enable,
  output logic [31:0] out_write_address,
  output logic [31:0] out_write_data,
  output logic        out_block_flush,
  output logic [31:0] out_block_flush_address,
  output logic        out_final_flush,
  output logic [31:0] out_final_flush_address,
  output logic        out_launch
);

  logic        enter;
  logic        s0_vld, s1_vld, match, push;
  item_t       s0_item, s1_item;
  logic [31:0] load_base;
  result_t     push_res, out_res;

  cwl_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_word          (in_word),
    .in_check_byte    (in_check_byte),
    .in_record_status (in_record_status),
    .enter            (enter),
    .s0_vld           (s0_vld),
    .s0_item          (s0_item),
    .load_base        (load_base)
  );

  cwl_check u_check (
    .clk     (clk),
    .rst_n   (rst_n),
    .s0_vld  (s0_vld),
    .s0_item (s0_item),
    .s1_vld  (s1_vld),
    .s1_item (s1_item),
    .match   (match)
  );

  cwl_seq #(
    .FLUSH_WORDS (FLUSH_WORDS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_vld    (s1_vld),
    .s1_item   (s1_item),
    .match     (match),
    .load_base (load_base),
    .push      (push),
    .push_res  (push_res)
  );

  cwl_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .enter     (enter),
    .push      (push),
    .push_res  (push_res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_res   (out_res),
    .in_stall  (in_stall)
  );

  assign out_ack_code            = out_res.ack_code;
  assign out_write_enable        = out_res.write_enable;
  assign out_write_address       = out_res.write_address;
  assign out_write_data          = out_res.write_data;
  assign out_block_flush         = out_res.block_flush;
  assign out_block_flush_address = out_res.block_flush_address;
  assign out_final_flush         = out_res.final_flush;
  assign out_final_flush_address = out_res.final_flush_address;
  assign out_launch              = out_res.launch;

endmodule

>>> tb/checked_word_loader_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for checked_word_loader_top: directed sessions, back-pressure
// and random load sessions, each result checked against an in-bench loader predictor.
// Depends on cwl_pkg (register indexes, result_t) and the checked_word_loader_top RTL.
module checked_word_loader_top_tb;
  import cwl_pkg::*;

  localparam int unsigned FLUSH_WORDS    = 8;
  localparam logic [31:0] CHECK_MODULUS  = 32'd230;
  localparam logic [1:0]  CFG_IDX_UNUSED = 2'd3;
  localparam int          DRAIN_CYCLES   = 8;
  localparam int          LONG_HOLD      = 60;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          RANDOM_RESULTS = 440;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_word = '0;
  logic [7:0]  in_check_byte = '0;
  logic [7:0]  in_record_status = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_ack_code;
  logic        out_write_enable;
  logic [31:0] out_write_address;
  logic [31:0] out_write_data;
  logic        out_block_flush;
  logic [31:0] out_block_flush_address;
  logic        out_final_flush;
  logic [31:0] out_final_flush_address;
  logic        out_launch;

  checked_word_loader_top #(.FLUSH_WORDS(FLUSH_WORDS)) dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Loader predictor: settings and session state
  logic [31:0] cur_marker = START_MARKER_RST;
  logic [31:0] cur_base   = LOAD_BASE_RST;
  logic [7:0]  cur_done   = DONE_CODE_RST;
  bit          sess_active = 1'b0;
  logic [31:0] wr_ptr = '0;
  logic [31:0] blk_base = '0;
  int unsigned blk_words = 0;

  result_t pending_results[$];
  int      fail_count = 0;
  int      result_items = 0;
  int      stuck_cycles = 0;
  bit      gaps_on = 1'b1;
  int      burst_left = 0;

  // Receiver control
  int          hold_req_seq = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  logic [31:0] rx_cycle = '0;
  int          rx_mode = 0;

  function automatic logic [7:0] check_of(input logic [31:0] w);
    return 8'(w % CHECK_MODULUS);
  endfunction

  function automatic bit predict_record(input logic [31:0] w, input logic [7:0] chk,
                                        input logic [7:0] st, output result_t res);
    res = '0;
    if (!sess_active) begin
      if (w != cur_marker) return 1'b0;
      sess_active = 1'b1;
      wr_ptr = cur_base;
      blk_base = cur_base;
      blk_words = 0;
      return 1'b1;
    end
    if ((w % CHECK_MODULUS) == {24'd0, chk}) begin
      res.write_enable = 1'b1;
      res.write_address = wr_ptr;
      res.write_data = w;
      wr_ptr = wr_ptr + 32'd4;
      if (blk_words >= FLUSH_WORDS - 1) begin
        res.block_flush = 1'b1;
        res.block_flush_address = blk_base;
        blk_base = wr_ptr;
        blk_words = 0;
      end else begin
        blk_words++;
      end
    end else begin
      res.ack_code = 1'b1;
    end
    if (st == cur_done) begin
      res.final_flush = 1'b1;
      res.final_flush_address = blk_base;
      res.launch = 1'b1;
      sess_active = 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic pace_sender();
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if (gaps_on) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  task automatic send_record(input logic [31:0] w, input logic [7:0] chk,
                             input logic [7:0] st);
    result_t res;
    pace_sender();
    in_valid <= 1'b1;
    in_word <= w;
    in_check_byte <= chk;
    in_record_status <= st;
    do @(posedge clk); while (in_stall);
    if (predict_record(w, chk, st, res)) begin
      pending_results.push_back(res);
      result_items++;
    end
  endtask

  // Wait until every expected result is out and the pipeline is empty
  task automatic drain_block();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_START_MARKER: cur_marker = data;
      CFG_LOAD_BASE:    cur_base = data;
      CFG_DONE_CODE:    cur_done = data[7:0];
      default: ;
    endcase
    // idle after the write so the next write does not land in the same step
    @(posedge clk);
  endtask

  // Optional idle noise, a marker, then code records; the last one ends the load if asked
  task automatic run_session(input int n_words, input bit finish, input int noise);
    logic [31:0] w;
    logic [7:0]  chk;
    logic [7:0]  st;
    if (!sess_active) begin
      repeat (noise) begin
        w = $urandom;
        if (w == cur_marker) w = ~w;
        send_record(w, 8'($urandom), 8'($urandom));
      end
      send_record(cur_marker, 8'($urandom), 8'($urandom));
    end
    for (int i = 0; i < n_words; i++) begin
      case ($urandom_range(0, 19))
        0:       w = '0;
        1:       w = '1;
        default: w = $urandom;
      endcase
      chk = ($urandom_range(0, 99) < 85) ? check_of(w) : 8'($urandom);
      st = 8'($urandom);
      if (finish && i == n_words - 1) st = cur_done;
      else if (st == cur_done) st = st ^ 8'h01;
      send_record(w, chk, st);
    end
  endtask

  task automatic test_default_session();
    send_record(32'h0000_0000, 8'hFF, DONE_CODE_RST);
    send_record(32'hFFFF_FFFF, 8'h00, 8'h00);
    send_record(START_MARKER_RST, 8'hFF, DONE_CODE_RST);
    send_record(32'h0000_0000, 8'h00, 8'h00);
    send_record(32'hFFFF_FFFF, check_of(32'hFFFF_FFFF), 8'hFF);
    send_record(START_MARKER_RST, check_of(START_MARKER_RST), 8'h01);
    send_record(32'd12345, 8'hFF, 8'h00);
    // failed check on the done record still ends the load
    send_record(32'd460, 8'd1, DONE_CODE_RST);
  endtask

  task automatic test_wrap_flush_on_done();
    logic [31:0] w;
    drain_block();
    write_reg(CFG_LOAD_BASE, 32'hFFFF_FFF0);
    write_reg(CFG_START_MARKER, 32'h0000_0000);
    write_reg(CFG_DONE_CODE, 32'hABCD_12FF);
    write_reg(CFG_IDX_UNUSED, 32'h5555_5555);
    send_record(32'h0000_0000, 8'h00, 8'h00);
    // eight good words cross the address wrap; the eighth also ends the load
    for (int i = 0; i < FLUSH_WORDS; i++) begin
      w = $urandom;
      send_record(w, check_of(w), (i == FLUSH_WORDS - 1) ? 8'hFF : 8'h7F);
    end
  endtask

  task automatic test_config_while_loading();
    drain_block();
    send_record(32'h0000_0000, 8'h00, 8'h00);
    send_record(32'd229, 8'd229, 8'h80);
    send_record(32'd231, 8'd1, 8'h00);
    drain_block();
    // new settings apply at once; write pointer and block base stay put
    write_reg(CFG_LOAD_BASE, 32'h0000_0000);
    write_reg(CFG_DONE_CODE, 32'h0000_0000);
    write_reg(CFG_START_MARKER, 32'hFFFF_FFFF);
    send_record(32'd7, 8'd8, 8'h00);
  endtask

  task automatic test_backpressure();
    drain_block();
    gaps_on = 1'b0;
    hold_req_seq <= hold_req_seq + 1;
    run_session(24, 1'b1, 0);
    gaps_on = 1'b1;
  endtask

  task automatic test_random_sessions();
    logic [31:0] v;
    int          goal;
    goal = result_items + RANDOM_RESULTS;
    while (result_items < goal) begin
      drain_block();
      case ($urandom_range(0, 2))
        0:       v = '0;
        1:       v = '1;
        default: v = $urandom;
      endcase
      write_reg(CFG_START_MARKER, v);
      case ($urandom_range(0, 3))
        0:       v = '0;
        1:       v = 32'hFFFF_FFFC;
        2:       v = 32'hFFFF_FFE2;
        default: v = $urandom;
      endcase
      write_reg(CFG_LOAD_BASE, v);
      v = $urandom;
      case ($urandom_range(0, 2))
        0:       v[7:0] = 8'h00;
        1:       v[7:0] = 8'hFF;
        default: ;
      endcase
      write_reg(CFG_DONE_CODE, v);
      if ($urandom_range(0, 3) == 0) write_reg(CFG_IDX_UNUSED, $urandom);
      gaps_on = ($urandom_range(0, 3) != 0);
      repeat (3) begin
        run_session(($urandom_range(0, 3) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 10),
                    $urandom_range(0, 7) != 0, $urandom_range(0, 3));
      end
    end
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      if (fail_count <= 10) $display("mismatch %s: expected %h, got %h", name, want, got);
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("unexpected result transaction at %0t", $realtime);
      end else begin
        want = pending_results.pop_front();
        compare_field("ack_code", want.ack_code, out_ack_code);
        compare_field("write_enable", want.write_enable, out_write_enable);
        compare_field("write_address", want.write_address, out_write_address);
        compare_field("write_data", want.write_data, out_write_data);
        compare_field("block_flush", want.block_flush, out_block_flush);
        compare_field("block_flush_address", want.block_flush_address,
                      out_block_flush_address);
        compare_field("final_flush", want.final_flush, out_final_flush);
        compare_field("final_flush_address", want.final_flush_address,
                      out_final_flush_address);
        compare_field("launch", want.launch, out_launch);
      end
    end
  end

  // Receiver: long hold on request, otherwise a stall pattern re-picked whenever rx_cycle[5:0] is zero
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req_seq != hold_seen) begin
      hold_seen <= hold_req_seq;
      hold_left <= LONG_HOLD;
      out_stall <= 1'b1;
    end else begin
      if (rx_cycle[5:0] == 6'd0) rx_mode <= $urandom_range(0, 3);
      case (rx_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        2:       out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= (rx_cycle[2:0] >= 3'd5);
      endcase
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
  end

  initial begin
    while (stuck_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_session();
    test_wrap_flush_on_done();
    test_config_while_loading();
    test_backpressure();
    test_random_sessions();
    drain_block();
    if (pending_results.size() != 0) fail_count++;
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
src/cwl_pkg.sv
src/cwl_front.sv
src/cwl_check.sv
src/cwl_seq.sv
src/cwl_queue.sv
src/checked_word_loader_top.sv
tb/checked_word_loader_top_tb.sv
